// ===== design/sdsg_pkg.sv =====
`timescale 1ns / 1ps
package sdsg_pkg;

    localparam int ROM_BITS   = 22;
    localparam int LN_STEPS   = 30;
    localparam int DIV_BITS   = 48;
    localparam int DIV_PER    = 4;
    localparam int SIG_BITS   = 17;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

    localparam logic [15:0] SHARP_RESET  = 16'd4096;
    localparam logic [15:0] THRESH_RESET = 16'd20480;

    typedef enum logic {
        CFG_SHARPNESS = 1'b0,
        CFG_THRESHOLD = 1'b1
    } cfg_idx_t;

    typedef logic [ROM_BITS:0][31:0] rom_t;

    // 2^(2^-k) in Q2.30, each entry the integer root of the previous one scaled by 2^30
    function automatic rom_t build_rom();
        rom_t              rom;
        longint unsigned   prev;
        longint unsigned   v;
        longint unsigned   r;
        longint unsigned   bitv;
        rom     = '0;
        prev    = 64'd1 << 31;
        rom[0]  = 32'h8000_0000;
        for (int k = 1; k <= ROM_BITS; k++) begin
            v    = prev << 30;
            r    = 64'd0;
            bitv = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (v >= r + bitv) begin
                    v = v - (r + bitv);
                    r = (r >> 1) + bitv;
                end else begin
                    r = r >> 1;
                end
                bitv = bitv >> 2;
            end
            rom[k] = r[31:0];
            prev   = r;
        end
        return rom;
    endfunction

    localparam rom_t POW_ROM = build_rom();

    typedef struct packed {
        logic               last;
        logic signed [16:0] x;
        logic signed [15:0] b;
        logic signed [15:0] ld;
        logic [15:0]        beta;
        logic signed [15:0] thr;
        logic signed [33:0] y;
        logic               lin;
        logic [28:0]        ub;
        logic [1:0][32:0]   t;
        logic [1:0][5:0]    sh;
        logic [1:0]         ez;
        logic [2:0][21:0]   fr;
        logic [2:0][30:0]   p;
        logic signed [7:0]  nb;
        logic [1:0][30:0]   e;
        logic [30:0]        m;
        logic [29:0]        r;
        logic               full;
        logic [29:0]        lnv;
        logic [15:0]        rem;
        logic [47:0]        num;
        logic [31:0]        dc;
        logic [31:0]        remc;
        logic [16:0]        qc;
        logic [15:0]        sig;
        logic               neg;
        logic               spz;
        logic [47:0]        spm;
        logic [4:0]         k;
        logic [31:0]        spn;
        logic signed [7:0]  sc;
        logic [62:0]        prod;
        logic               ovf;
        logic [23:0]        val;
        logic [23:0]        g;
    } item_t;

    typedef struct packed {
        logic [15:0] sig;
        logic [23:0] decay;
        logic        clip;
        logic        last;
    } res_t;

endpackage

// ===== design/softplus_decay_sigmoid_gate_top.sv =====
`timescale 1ns / 1ps
// Softplus decay and sigmoid gate, one element per transfer.
// Input channel s_*: tdata carries gate_in, beta_in, log_decay, head_bias
// (16 bits each, lowest first), tlast marks the final element.
// Output channel m_*: tdata carries decay_out (24 bits) then sigmoid_out
// (16 bits), tuser is the clipped flag, tlast is the copied marker.
// Config channel cfg_*: index 0 sets softplus_sharpness, 1 sets
// linear_threshold; write only while no element is in flight.
// Throughput is one element per cycle while the skid buffer is empty.
// The transfer edge loads the first of the 77 pipeline stages and the
// output register follows the last. The stages hold the 22-step power
// ROM chains, the 30 squaring steps of the logarithm and the 48-bit
// divide by the sharpness at four quotient bits a stage.
// Reset clears all valid bits and restores both registers to their defaults.
// When the receiver stalls, an output register and a one-entry skid buffer
// catch the pipeline's last result; s_tready drops only while the skid
// buffer is full and the whole pipeline holds.
module softplus_decay_sigmoid_gate_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // gate_in, beta_in, log_decay, head_bias
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // decay_out, sigmoid_out
    output logic        m_tuser,   // clipped
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ST_MUL   = 2;
    localparam int ST_TA    = 3;
    localparam int ST_PREP  = 4;
    localparam int ST_POW   = 5;
    localparam int ST_EXP   = ST_POW + sdsg_pkg::ROM_BITS;
    localparam int ST_INIT  = ST_EXP + 1;
    localparam int ST_LN    = ST_INIT + 1;
    localparam int ST_SDIV  = ST_INIT + 1;
    localparam int ST_SIG   = ST_SDIV + sdsg_pkg::SIG_BITS;
    localparam int ST_LNV   = ST_LN + sdsg_pkg::LN_STEPS;
    localparam int ST_NUM   = ST_LNV + 1;
    localparam int ST_DIV   = ST_NUM + 1;
    localparam int ST_SP    = ST_DIV + sdsg_pkg::DIV_BITS / sdsg_pkg::DIV_PER;
    localparam int ST_NORM  = ST_SP + 1;
    localparam int ST_PROD  = ST_NORM + 1;
    localparam int ST_SAT   = ST_PROD + 1;
    localparam int ST_G     = ST_SAT + 1;
    localparam int NS       = ST_G;

    logic [15:0]          sharp_reg;
    logic [15:0]          thr_reg;
    sdsg_pkg::item_t      pipe_reg  [1:NS];
    sdsg_pkg::item_t      pipe_next [1:NS];
    logic [NS:1]          vld_reg;
    sdsg_pkg::res_t       out_reg;
    logic                 out_vld_reg;
    sdsg_pkg::res_t       skid_reg;
    logic                 skid_vld_reg;
    sdsg_pkg::res_t       fin;
    logic                 adv;
    logic                 out_take;

    assign cfg_ready = 1'b1;
    assign adv       = !skid_vld_reg;
    assign s_tready  = adv;
    assign out_take  = out_vld_reg && m_tready;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {out_reg.sig, out_reg.decay};
    assign m_tuser   = out_reg.clip;
    assign m_tlast   = out_reg.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sharp_reg <= sdsg_pkg::SHARP_RESET;
            thr_reg   <= sdsg_pkg::THRESH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (sdsg_pkg::cfg_idx_t'(cfg_index))
                sdsg_pkg::CFG_SHARPNESS: sharp_reg <= cfg_data;
                sdsg_pkg::CFG_THRESHOLD: thr_reg   <= cfg_data;
            endcase
        end
    end

    always_comb begin
        sdsg_pkg::item_t    it;
        logic [4:0]         kk;
        logic [62:0]        mulw;
        logic [61:0]        sq;
        logic [31:0]        mm;
        logic [33:0]        yabs;
        logic signed [33:0] thrw;
        logic signed [47:0] ldw;
        logic [15:0]        bmag;
        logic [10:0]        nn;
        logic [21:0]        fpart;
        logic               fz;
        logic [11:0]        shw;
        logic [31:0]        m32;
        logic [32:0]        rrc;
        logic [32:0]        diffc;
        logic [59:0]        mul60;
        logic [39:0]        pos;
        logic [40:0]        s41;
        logic [16:0]        rr;
        logic [16:0]        beta17;
        logic [16:0]        xmag;
        logic [23:0]        lim24;
        logic [7:0]         nsu;
        logic [62:0]        sv;
        logic [23:0]        mag;

        it        = '0;
        it.last   = s_tlast;
        it.x      = 17'($signed(s_tdata[15:0])) + 17'($signed(s_tdata[63:48]));
        it.b      = $signed(s_tdata[31:16]);
        it.ld     = $signed(s_tdata[47:32]);
        it.beta   = (sharp_reg == 16'd0) ? 16'd1 : sharp_reg;
        it.thr    = $signed(thr_reg);
        pipe_next[1] = it;

        for (int s = 2; s <= NS; s++) begin
            it    = pipe_reg[s-1];
            kk    = '0;
            mulw  = '0;
            sq    = '0;
            mm    = '0;
            yabs  = '0;
            thrw  = '0;
            ldw   = '0;
            bmag  = '0;
            nn    = '0;
            fpart = '0;
            fz    = 1'b0;
            shw   = '0;
            m32   = '0;
            rrc   = '0;
            diffc = '0;
            mul60 = '0;
            pos   = '0;
            s41   = '0;
            rr    = '0;
            beta17 = '0;
            xmag  = '0;
            lim24 = '0;
            nsu   = '0;
            sv    = '0;
            mag   = '0;

            if (s == ST_MUL) begin
                it.y  = it.x * $signed({1'b0, it.beta});
                ldw   = it.ld * $signed({17'd0, sdsg_pkg::LOG2E_Q30});
                ldw   = ldw + 48'sh4000_0000_0000;
                it.ub = ldw[46:18];
                bmag  = it.b[15] ? 16'(-it.b) : 16'(it.b);
                mulw  = 63'({bmag, 12'd0}) * 63'(sdsg_pkg::LOG2E_Q30);
                it.t[1] = 33'(mulw[62:30]);
            end

            if (s == ST_TA) begin
                thrw   = 34'(it.thr) <<< 12;
                it.lin = it.y > thrw;
                yabs   = it.y[33] ? 34'(-it.y) : 34'(it.y);
                mulw   = 63'(yabs[31:0]) * 63'(sdsg_pkg::LOG2E_Q30);
                it.t[0] = mulw[62:30];
            end

            if (s == ST_PREP) begin
                for (int j = 0; j < 2; j++) begin
                    nn       = it.t[j][32:22];
                    fpart    = it.t[j][21:0];
                    fz       = (fpart == 22'd0);
                    it.fr[j] = fz ? 22'd0 : 22'(23'h40_0000 - {1'b0, fpart});
                    shw      = {1'b0, nn} + {11'd0, !fz};
                    it.ez[j] = (shw >= 12'd40);
                    it.sh[j] = shw[5:0];
                end
                it.fr[2] = it.ub[21:0];
                it.nb    = $signed({1'b0, it.ub[28:22]}) - 8'sd64;
                for (int j = 0; j < 3; j++) begin
                    it.p[j] = sdsg_pkg::Q30_ONE;
                end
            end

            if (s >= ST_POW && s < ST_EXP) begin
                kk = 5'(s - ST_POW + 1);
                for (int j = 0; j < 3; j++) begin
                    if (it.fr[j][5'(sdsg_pkg::ROM_BITS) - kk]) begin
                        mulw    = 63'(it.p[j]) * 63'(sdsg_pkg::POW_ROM[kk][30:0]);
                        it.p[j] = mulw[60:30];
                    end
                end
            end

            if (s == ST_EXP) begin
                for (int j = 0; j < 2; j++) begin
                    it.e[j] = it.ez[j] ? 31'd0 : (it.p[j] >> it.sh[j]);
                end
            end

            if (s == ST_INIT) begin
                m32     = {1'b0, sdsg_pkg::Q30_ONE} + {1'b0, it.e[0]};
                it.full = m32[31];
                it.m    = m32[30:0];
                it.r    = '0;
                it.dc   = {1'b0, sdsg_pkg::Q30_ONE} + {1'b0, it.e[1]};
                if (!it.b[15]) begin
                    it.remc = 32'h2000_0000;
                    it.qc   = '0;
                end else begin
                    it.remc = {2'd0, it.e[1][30:1]};
                    it.qc   = {it.e[1][0], 16'd0};
                end
            end

            if (s >= ST_LN && s < ST_LNV) begin
                sq   = 62'(it.m) * 62'(it.m);
                mm   = sq[61:30];
                it.r = {it.r[28:0], mm[31]};
                it.m = mm[31] ? mm[31:1] : mm[30:0];
            end

            if (s >= ST_SDIV && s < ST_SIG) begin
                rrc     = {it.remc, it.qc[16]};
                diffc   = rrc - {1'b0, it.dc};
                it.remc = (rrc >= {1'b0, it.dc}) ? diffc[31:0] : rrc[31:0];
                it.qc   = {it.qc[15:0], (rrc >= {1'b0, it.dc})};
            end

            if (s == ST_SIG) begin
                it.sig = it.qc[16] ? 16'hFFFF : it.qc[15:0];
            end

            if (s == ST_LNV) begin
                mul60  = 60'(it.r) * 60'(sdsg_pkg::LN2_Q30);
                it.lnv = it.full ? sdsg_pkg::LN2_Q30 : mul60[59:30];
            end

            if (s == ST_NUM) begin
                pos    = (it.y > 34'sd0) ? {it.y[31:0], 8'd0} : 40'd0;
                s41    = 41'(pos) + 41'(it.lnv);
                it.num = {1'b0, s41, 6'd0};
                it.rem = '0;
            end

            if (s >= ST_DIV && s < ST_SP) begin
                beta17 = {1'b0, it.beta};
                for (int q = 0; q < sdsg_pkg::DIV_PER; q++) begin
                    rr     = {it.rem, it.num[47]};
                    it.num = {it.num[46:0], (rr >= beta17)};
                    it.rem = (rr >= beta17) ? 16'(rr - beta17) : rr[15:0];
                end
            end

            if (s == ST_SP) begin
                xmag = it.x[16] ? 17'(-it.x) : 17'(it.x);
                if (it.lin) begin
                    it.neg = !it.x[16] && (it.x != 17'sd0);
                    it.spm = 48'({xmag, 14'd0});
                end else begin
                    it.neg = (it.num != 48'd0);
                    it.spm = it.num;
                end
                it.spz = (it.spm == 48'd0);
                it.k   = '0;
                for (int i = 32; i < 48; i++) begin
                    if (it.spm[i]) begin
                        it.k = 5'(i - 31);
                    end
                end
            end

            if (s == ST_NORM) begin
                it.spn = 32'(it.spm >> it.k);
                it.sc  = it.nb + $signed({3'd0, it.k}) - 8'sd42;
            end

            if (s == ST_PROD) begin
                it.prod = 63'(it.p[2]) * 63'(it.spn);
            end

            if (s == ST_SAT) begin
                lim24 = it.neg ? 24'h80_0000 : 24'h7F_FFFF;
                if (it.spz) begin
                    it.ovf = 1'b0;
                    it.val = '0;
                end else if (!it.sc[7]) begin
                    it.ovf = (it.sc >= 8'sd40) ||
                             (it.prod > (63'(lim24) >> it.sc[5:0]));
                    it.val = 24'(it.prod << it.sc[5:0]);
                end else begin
                    nsu    = 8'(-it.sc);
                    sv     = (nsu >= 8'd64) ? 63'd0 : (it.prod >> nsu[5:0]);
                    it.ovf = (sv > 63'(lim24));
                    it.val = sv[23:0];
                end
            end

            if (s == ST_G) begin
                lim24 = it.neg ? 24'h80_0000 : 24'h7F_FFFF;
                mag   = it.ovf ? lim24 : it.val;
                it.g  = it.neg ? 24'(~mag + 24'd1) : mag;
            end

            pipe_next[s] = it;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NS-1:1], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int s = 1; s <= NS; s++) begin
                pipe_reg[s] <= pipe_next[s];
            end
        end
    end

    always_comb begin
        fin.sig   = pipe_reg[NS].sig;
        fin.decay = pipe_reg[NS].g;
        fin.clip  = pipe_reg[NS].ovf;
        fin.last  = pipe_reg[NS].last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (adv) begin
            if (vld_reg[NS]) begin
                if (!out_vld_reg || out_take) begin
                    out_vld_reg <= 1'b1;
                end else begin
                    skid_vld_reg <= 1'b1;
                end
            end else if (out_take) begin
                out_vld_reg <= 1'b0;
            end
        end else if (out_take) begin
            skid_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (vld_reg[NS]) begin
                if (!out_vld_reg || out_take) begin
                    out_reg <= fin;
                end else begin
                    skid_reg <= fin;
                end
            end
        end else if (out_take) begin
            out_reg <= skid_reg;
        end
    end

endmodule

// ===== design/sdsg_checker.sv =====
`timescale 1ns / 1ps
module sdsg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        cfg_index,
    input logic [15:0] cfg_data
);

    // hold the result while the receiver stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                  $stable(m_tuser) && $stable(m_tlast))
        else $error("output changed during stall");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (m_tdata[23:0] == 24'h80_0000 || m_tdata[23:0] == 24'h7F_FFFF))
        else $error("clipped result not at a limit");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input blocked with no result waiting");

    a_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && !m_tready |=> !s_tready)
        else $error("input reopened without an output transfer");

endmodule

bind softplus_decay_sigmoid_gate_top sdsg_checker u_sdsg_checker (.*);

// ===== bench/sdsg_checker.sv =====
`timescale 1ns / 1ps
module sdsg_scoreboard (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          n_pending,
    output int          n_errors
);

    typedef struct packed {
        logic [23:0] decay;
        logic [15:0] sig;
        logic        clip;
        logic        last;
    } gate_res_t;

    localparam longint unsigned ONE_Q30 = 64'd1073741824;
    localparam longint unsigned L2E     = 64'd1549082005;
    localparam longint unsigned LN2     = 64'd744261118;
    localparam longint unsigned FMASK   = 64'd4194303;

    longint unsigned root_tab [1:22];
    logic [15:0]     sharp;
    logic [15:0]     thresh;
    gate_res_t       expected_q [$];

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint unsigned frac_pow2(longint unsigned f);
        longint unsigned p;
        p = ONE_Q30;
        for (int k = 1; k <= 22; k++)
            if (((f >> (22 - k)) & 1) != 0) p = (p * root_tab[k]) >> 30;
        return p;
    endfunction

    function automatic longint unsigned exp_minus(longint unsigned z);
        longint unsigned t;
        longint unsigned n;
        longint unsigned f;
        longint unsigned mt;
        longint unsigned sh;
        if (z >= (64'd1 << 32)) return 0;
        t = (z * L2E) >> 30;
        n = t >> 22;
        f = t & FMASK;
        if (f == 0) begin
            mt = ONE_Q30;
            sh = n;
        end else begin
            mt = frac_pow2(FMASK + 1 - f);
            sh = n + 1;
        end
        return (sh >= 40) ? 64'd0 : (mt >> sh);
    endfunction

    function automatic longint unsigned log1p_q30(longint unsigned e);
        longint unsigned m;
        longint unsigned r;
        m = ONE_Q30 + e;
        r = 0;
        if (m >= 2 * ONE_Q30) return LN2;
        for (int i = 0; i < 30; i++) begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= 2 * ONE_Q30) begin
                m = m >> 1;
                r = r | 1;
            end
        end
        return (r * LN2) >> 30;
    endfunction

    function automatic gate_res_t gate_predict(logic [63:0] d, logic lst);
        gate_res_t       res;
        longint          a, b, ld, bias, thr, bt, x, y, sp, g, sgn;
        longint unsigned z, pos, s30, u, mt, spm, prod, mag, lim, e, sg;
        int              n, k, s;
        logic            clip, neg;
        a    = longint'($signed(d[15:0]));
        b    = longint'($signed(d[31:16]));
        ld   = longint'($signed(d[47:32]));
        bias = longint'($signed(d[63:48]));
        thr  = longint'($signed(thresh));
        bt   = longint'(sharp);
        if (bt == 0) bt = 1;
        clip = 1'b0;
        k    = 0;
        x = a + bias;
        y = x * bt;
        if (y <= thr * 4096) begin
            z   = longint'(y < 0 ? -y : y);
            pos = (y > 0) ? (longint'(y) << 8) : 64'd0;
            s30 = pos + log1p_q30(exp_minus(z));
            sp  = longint'((s30 << 6) / longint'(bt));
        end else begin
            sp = x * 16384;
        end
        sgn = ld * longint'(L2E) + (longint'(64) << 40);
        u   = longint'(sgn) >> 18;
        n   = int'(u >> 22) - 64;
        mt  = frac_pow2(u & FMASK);
        neg = sp > 0;
        spm = longint'(sp < 0 ? -sp : sp);
        lim = neg ? 64'd8388608 : 64'd8388607;
        if (spm == 0) begin
            mag = 0;
        end else begin
            while (spm >= (64'd1 << 32)) begin
                spm = spm >> 1;
                k++;
            end
            prod = mt * spm;
            s = n + k - 42;
            if (s >= 0) begin
                if (s >= 40 || prod > (lim >> s)) begin
                    mag  = lim;
                    clip = 1'b1;
                end else begin
                    mag = prod << s;
                end
            end else begin
                mag = (-s >= 64) ? 64'd0 : (prod >> (-s));
                if (mag > lim) begin
                    mag  = lim;
                    clip = 1'b1;
                end
            end
        end
        g = neg ? -longint'(mag) : longint'(mag);
        e = exp_minus(longint'(b < 0 ? -b : b) << 12);
        if (b >= 0) sg = (64'd1 << 46) / (ONE_Q30 + e);
        else sg = (e << 16) / (ONE_Q30 + e);
        if (sg > 65535) sg = 65535;
        res.decay = g[23:0];
        res.sig   = sg[15:0];
        res.clip  = clip;
        res.last  = lst;
        return res;
    endfunction

    initial begin
        longint unsigned prev;
        prev = 64'd2 * ONE_Q30;
        for (int k = 1; k <= 22; k++) begin
            root_tab[k] = isqrt(prev << 30);
            prev = root_tab[k];
        end
        n_errors  = 0;
        n_pending = 0;
        sharp     = sdsg_pkg::SHARP_RESET;
        thresh    = sdsg_pkg::THRESH_RESET;
    end

    always @(posedge aclk) begin
        gate_res_t exp_r;
        if (!aresetn) begin
            sharp  = sdsg_pkg::SHARP_RESET;
            thresh = sdsg_pkg::THRESH_RESET;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == sdsg_pkg::CFG_SHARPNESS) sharp = cfg_data;
                else if (cfg_index == sdsg_pkg::CFG_THRESHOLD) thresh = cfg_data;
            end
            if (s_tvalid && s_tready) expected_q.push_back(gate_predict(s_tdata, s_tlast));
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result transfer: decay_out %0h", m_tdata[23:0]);
                    n_errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_tdata[23:0] !== exp_r.decay) begin
                        $error("decay_out expected %0h actual %0h", exp_r.decay, m_tdata[23:0]);
                        n_errors++;
                    end
                    if (m_tdata[39:24] !== exp_r.sig) begin
                        $error("sigmoid_out expected %0h actual %0h", exp_r.sig, m_tdata[39:24]);
                        n_errors++;
                    end
                    if (m_tuser !== exp_r.clip) begin
                        $error("clipped expected %0b actual %0b", exp_r.clip, m_tuser);
                        n_errors++;
                    end
                    if (m_tlast !== exp_r.last) begin
                        $error("last_out expected %0b actual %0b", exp_r.last, m_tlast);
                        n_errors++;
                    end
                end
            end
        end
        n_pending = expected_q.size();
    end

endmodule

// ===== bench/tb_softplus_decay_sigmoid_gate_top.sv =====
`timescale 1ns / 1ps
module tb_softplus_decay_sigmoid_gate_top;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;   // gate_in, beta_in, log_decay, head_bias
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // decay_out, sigmoid_out
    logic        m_tuser;   // clipped
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [15:0] cfg_data;
    int          n_pending;
    int          n_errors;
    int          sent;
    int          burst_left;

    softplus_decay_sigmoid_gate_top u_dut (.*);

    sdsg_scoreboard u_chk (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // receiver: rotate through stall modes, with one long hold-off mid-run
    initial begin
        int cyc;
        int hold;
        bit held;
        cyc  = 0;
        hold = 0;
        held = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (!held && sent >= 150) begin
                held = 1;
                hold = 300;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                case ((cyc / 97) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (cyc % 5) != 0;
                endcase
            end
        end
    end

    function automatic logic [15:0] pick_q610();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2, 3: return 16'($signed($urandom_range(0, 8191)) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_elem(logic [15:0] a, logic [15:0] b, logic [15:0] ld,
                             logic [15:0] bias, logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {bias, ld, b, a};
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (n_pending != 0);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(sdsg_pkg::cfg_idx_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_run(int cnt);
        for (int i = 0; i < cnt; i++)
            send_elem(pick_q610(), pick_q610(), pick_q610(), pick_q610(),
                      $urandom_range(0, 15) == 0);
    endtask

    initial begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = sdsg_pkg::CFG_SHARPNESS;
        cfg_data   = '0;
        sent       = 0;
        burst_left = 0;
        aresetn    = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, sigmoid top, decay overflow, small values
        send_elem(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_elem(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        send_elem(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
        send_elem(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
        send_elem(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0);
        send_elem(16'h0400, 16'h2000, 16'h7FFF, 16'h0400, 1'b0);
        send_elem(16'hFC00, 16'hE000, 16'h1000, 16'h0000, 1'b0);
        send_elem(16'h5000, 16'h0001, 16'h0000, 16'h0000, 1'b0);
        send_elem(16'h5001, 16'hFFFF, 16'h0000, 16'h0000, 1'b0);
        send_elem(16'h4FFF, 16'h5555, 16'hAAAA, 16'h0001, 1'b1);
        send_elem(16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 1'b0);
        send_elem(16'hFFFF, 16'h0400, 16'hFC00, 16'hFFFF, 1'b0);
        send_elem(16'h3000, 16'h6000, 16'h3000, 16'h3000, 1'b1);
        random_run(70);
        drain();

        write_reg(sdsg_pkg::CFG_SHARPNESS, 16'hFFFF);
        write_reg(sdsg_pkg::CFG_THRESHOLD, 16'h7FFF);
        random_run(90);
        drain();

        write_reg(sdsg_pkg::CFG_SHARPNESS, 16'h0001);
        write_reg(sdsg_pkg::CFG_THRESHOLD, 16'h8000);
        send_elem(16'h8000, 16'h0000, 16'h7FFF, 16'h8000, 1'b0);
        send_elem(16'hF000, 16'h0000, 16'h2000, 16'h0000, 1'b1);
        random_run(90);
        drain();

        // zero sharpness behaves as the smallest one
        write_reg(sdsg_pkg::CFG_SHARPNESS, 16'h0000);
        write_reg(sdsg_pkg::CFG_THRESHOLD, 16'h0000);
        random_run(90);
        drain();

        // negative threshold lets negative x take the linear path
        write_reg(sdsg_pkg::CFG_SHARPNESS, 16'd2048);
        write_reg(sdsg_pkg::CFG_THRESHOLD, 16'hEC78);
        send_elem(16'hF000, 16'h0100, 16'h7FFF, 16'hF000, 1'b0);
        send_elem(16'hFC00, 16'h0100, 16'h0400, 16'h0000, 1'b0);
        random_run(90);
        drain();

        write_reg(sdsg_pkg::CFG_SHARPNESS, 16'($urandom));
        write_reg(sdsg_pkg::CFG_THRESHOLD, 16'($urandom));
        random_run(90);
        drain();

        if (n_errors == 0 && n_pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
